### hw/rtl/lds_pkg.sv
// Shared types and constants of the five-point diffusion stencil.
`default_nettype none
package lds_pkg;

	localparam int MAX_WIDTH_DEF    = 1024;
	localparam int AMOUNT_BITS_DEF  = 16;
	localparam int GRID_WIDTH_BITS  = 11;
	localparam int GRID_HEIGHT_BITS = 13;
	localparam int ROW_BITS         = 12;
	localparam int RATE_BITS        = 16;
	localparam int RATE_FRAC_BITS   = 16;
	localparam int HEIGHT_LIMIT     = 4096;
	localparam int CFG_INDEX_BITS   = 2;
	localparam int CFG_DATA_BITS    = 16;

	localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 11'd1024;
	localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 13'd1024;
	localparam logic [RATE_BITS-1:0]        RATE_RESET        = 16'd0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_GRID_WIDTH  = 2'd0,
		CFG_GRID_HEIGHT = 2'd1,
		CFG_RATE        = 2'd2
	} cfg_index_t;

	// Position class of one cell, worked out when the cell enters.
	typedef struct packed {
		logic emit;
		logic interior;
		logic has_left;
		logic has_right;
		logic eog;
	} cell_flags_t;

endpackage
`default_nettype wire

### hw/rtl/laplacian_diffusion_stencil_top.sv
// Top level of the streaming five-point Laplacian diffusion stencil.
// Cells enter in raster order, one per clock unless stalled, and each cell leaves exactly
// one grid row after it entered, so the last row of a grid leaves while the first row of the
// next grid enters; the first row after reset gives no results. Sustained rate is one cell
// per cycle unless stalled, set by the middle-row line memory, which takes one write and two
// reads per accepted cell. The last input of a row reaches its matching output through
// memory read, Laplacian, multiply, and floor and saturate into the output register. in_stall
// rises only while the one-entry skid behind the output register is occupied. Border cells
// pass through; interior cells get center + floor(rate * Laplacian / 65536), saturated.
// grid_width, grid_height and rate should be written only while no item is in flight.
`default_nettype none
module laplacian_diffusion_stencil_top #(
	parameter int MAX_WIDTH   = lds_pkg::MAX_WIDTH_DEF,
	parameter int AMOUNT_BITS = lds_pkg::AMOUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lds_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [lds_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [AMOUNT_BITS-1:0]              cell_amount,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [AMOUNT_BITS-1:0]                   new_amount,
	output logic                                     end_of_burst,
	output logic                                     end_of_grid
);

	localparam int XW = $clog2(MAX_WIDTH);

	logic [lds_pkg::GRID_WIDTH_BITS-1:0]  grid_width_q;
	logic [lds_pkg::GRID_HEIGHT_BITS-1:0] grid_height_q;
	logic [lds_pkg::RATE_BITS-1:0]        rate_q;

	logic                   en;
	logic                   accept;
	logic [XW-1:0]          rd_x;
	logic [XW-1:0]          rd_x_right;
	lds_pkg::cell_flags_t   flags;
	logic                   s1_valid;
	lds_pkg::cell_flags_t   s1_flags;
	logic [AMOUNT_BITS-1:0] s1_cell;
	logic [AMOUNT_BITS-1:0] center;
	logic [AMOUNT_BITS-1:0] right;
	logic [AMOUNT_BITS-1:0] up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= lds_pkg::GRID_WIDTH_RESET;
			grid_height_q <= lds_pkg::GRID_HEIGHT_RESET;
			rate_q        <= lds_pkg::RATE_RESET;
		end else if (cfg_we) begin
			unique case (lds_pkg::cfg_index_t'(cfg_index))
				lds_pkg::CFG_GRID_WIDTH: begin
					grid_width_q <= cfg_data[lds_pkg::GRID_WIDTH_BITS-1:0];
				end
				lds_pkg::CFG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data[lds_pkg::GRID_HEIGHT_BITS-1:0];
				end
				lds_pkg::CFG_RATE: begin
					rate_q <= cfg_data[lds_pkg::RATE_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall     = !en;
	assign accept       = in_valid && en;
	assign end_of_burst = 1'b1;

	lds_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.rd_x        (rd_x),
		.rd_x_right  (rd_x_right),
		.flags       (flags)
	);

	lds_line_buf #(
		.MAX_WIDTH   (MAX_WIDTH),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_line_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.accept     (accept),
		.rd_x       (rd_x),
		.rd_x_right (rd_x_right),
		.flags      (flags),
		.amount_in  (cell_amount),
		.s1_valid   (s1_valid),
		.s1_flags   (s1_flags),
		.s1_cell    (s1_cell),
		.center     (center),
		.right      (right),
		.up         (up)
	);

	lds_diffuse #(
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_diffuse (
		.clk         (clk),
		.arst_n      (arst_n),
		.rate        (rate_q),
		.s1_valid    (s1_valid),
		.s1_flags    (s1_flags),
		.s1_cell     (s1_cell),
		.center      (center),
		.right       (right),
		.up          (up),
		.en          (en),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.new_amount  (new_amount),
		.end_of_grid (end_of_grid)
	);

endmodule
`default_nettype wire

### hw/rtl/lds_ctrl.sv
// Raster position counters and cell classification for the diffusion stencil.
`default_nettype none
module lds_ctrl #(
	parameter int MAX_WIDTH = lds_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  accept,
	input  wire logic [lds_pkg::GRID_WIDTH_BITS-1:0]   grid_width,
	input  wire logic [lds_pkg::GRID_HEIGHT_BITS-1:0]  grid_height,
	output logic [$clog2(MAX_WIDTH)-1:0]               rd_x,
	output logic [$clog2(MAX_WIDTH)-1:0]               rd_x_right,
	output lds_pkg::cell_flags_t                       flags
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int WW   = XW + 1;
	localparam int GW   = lds_pkg::GRID_WIDTH_BITS;
	localparam int GH   = lds_pkg::GRID_HEIGHT_BITS;
	localparam int RB   = lds_pkg::ROW_BITS;
	localparam int CMPW = (WW > GW) ? WW : GW;

	logic [XW-1:0]   col_q;
	logic [RB-1:0]   row_q;
	logic            seen_q;
	logic [CMPW-1:0] gw_ext;
	logic [WW-1:0]   w_eff;
	logic [GH-1:0]   h_eff;
	logic [XW-1:0]   x;
	logic [RB-1:0]   y;
	logic [WW-1:0]   x_inc;
	logic [GH-1:0]   y_inc;
	logic            last_col;
	logic            last_row;

	always_comb begin
		gw_ext = CMPW'(grid_width);
		if (grid_width == '0) begin
			w_eff = WW'(1);
		end else if (gw_ext > CMPW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(gw_ext);
		end
		if (grid_height == '0) begin
			h_eff = GH'(1);
		end else if (grid_height > GH'(lds_pkg::HEIGHT_LIMIT)) begin
			h_eff = GH'(lds_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = grid_height;
		end
		// A position left beyond a shrunk geometry clamps to the last column or row.
		if ({1'b0, col_q} >= w_eff) begin
			x = XW'(w_eff - WW'(1));
		end else begin
			x = col_q;
		end
		if ({1'b0, row_q} >= h_eff) begin
			y = RB'(h_eff - GH'(1));
		end else begin
			y = row_q;
		end
		x_inc    = {1'b0, x} + WW'(1);
		y_inc    = {1'b0, y} + GH'(1);
		last_col = (x_inc == w_eff);
		last_row = (y_inc == h_eff);

		rd_x           = x;
		rd_x_right     = last_col ? x : x_inc[XW-1:0];
		flags.emit     = (y != '0) || seen_q;
		flags.has_left = (x != '0);
		flags.has_right = !last_col;
		flags.interior = (y >= RB'(2)) && (x != '0) && !last_col;
		flags.eog      = (y == '0) && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			seen_q <= 1'b0;
		end else if (accept) begin
			if (last_col) begin
				col_q  <= '0;
				seen_q <= 1'b1;
				row_q  <= last_row ? '0 : y_inc[RB-1:0];
			end else begin
				col_q <= x_inc[XW-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lds_line_buf.sv
// Two line memories holding the rows above the input row, with write forwarding.
`default_nettype none
module lds_line_buf #(
	parameter int MAX_WIDTH   = lds_pkg::MAX_WIDTH_DEF,
	parameter int AMOUNT_BITS = lds_pkg::AMOUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          accept,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_x,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]  rd_x_right,
	input  wire lds_pkg::cell_flags_t          flags,
	input  wire logic [AMOUNT_BITS-1:0]        amount_in,
	output logic                               s1_valid,
	output lds_pkg::cell_flags_t               s1_flags,
	output logic [AMOUNT_BITS-1:0]             s1_cell,
	output logic [AMOUNT_BITS-1:0]             center,
	output logic [AMOUNT_BITS-1:0]             right,
	output logic [AMOUNT_BITS-1:0]             up
);

	localparam int XW = $clog2(MAX_WIDTH);

	logic [AMOUNT_BITS-1:0] mid_mem [MAX_WIDTH];
	logic [AMOUNT_BITS-1:0] upr_mem [MAX_WIDTH];

	logic                   valid_s1;
	logic [XW-1:0]          x_s1;
	lds_pkg::cell_flags_t   flags_s1;
	logic [AMOUNT_BITS-1:0] cell_s1;
	logic [AMOUNT_BITS-1:0] mid_c_s1;
	logic [AMOUNT_BITS-1:0] mid_r_s1;
	logic [AMOUNT_BITS-1:0] upr_s1;
	logic                   fwd_s1;
	logic [AMOUNT_BITS-1:0] fwd_data_s1;
	logic                   upr_we;

	// The middle row moves into the upper row once its old value has been read.
	assign upr_we = en && valid_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_c_s1     <= mid_mem[rd_x];
			mid_r_s1     <= mid_mem[rd_x_right];
			upr_s1       <= upr_mem[rd_x];
			mid_mem[rd_x] <= amount_in;
			x_s1         <= rd_x;
			flags_s1     <= flags;
			cell_s1      <= amount_in;
			// The upper-row write lands on the same edge as this read.
			fwd_s1       <= upr_we && (x_s1 == rd_x);
			fwd_data_s1  <= mid_c_s1;
		end
		if (upr_we) begin
			upr_mem[x_s1] <= mid_c_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_flags = flags_s1;
	assign s1_cell  = cell_s1;
	assign center   = mid_c_s1;
	assign right    = flags_s1.has_right ? mid_r_s1 : '0;
	assign up       = fwd_s1 ? fwd_data_s1 : upr_s1;

endmodule
`default_nettype wire

### hw/rtl/lds_diffuse.sv
// Laplacian, rate multiply, floor and saturation stages with the output skid register.
`default_nettype none
module lds_diffuse #(
	parameter int AMOUNT_BITS = lds_pkg::AMOUNT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lds_pkg::RATE_BITS-1:0]   rate,
	input  wire logic                            s1_valid,
	input  wire lds_pkg::cell_flags_t            s1_flags,
	input  wire logic [AMOUNT_BITS-1:0]          s1_cell,
	input  wire logic [AMOUNT_BITS-1:0]          center,
	input  wire logic [AMOUNT_BITS-1:0]          right,
	input  wire logic [AMOUNT_BITS-1:0]          up,
	output logic                                 en,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [AMOUNT_BITS-1:0]               new_amount,
	output logic                                 end_of_grid
);

	localparam int A  = AMOUNT_BITS;
	localparam int LW = A + 3;
	localparam int PW = LW + lds_pkg::RATE_BITS + 1;
	localparam int FB = lds_pkg::RATE_FRAC_BITS;
	localparam int DW = PW - FB;
	localparam int SW = DW + 1;

	logic [A-1:0]           left_q;
	logic [A-1:0]           left;
	logic [A+1:0]           nbr_sum;
	logic signed [LW-1:0]   lap;

	logic                   valid_s2;
	logic signed [LW-1:0]   lap_s2;
	logic [A-1:0]           center_s2;
	logic                   interior_s2;
	logic                   eog_s2;

	logic                   valid_s3;
	logic signed [PW-1:0]   prod_s3;
	logic [A-1:0]           center_s3;
	logic                   interior_s3;
	logic                   eog_s3;

	logic signed [lds_pkg::RATE_BITS:0] rate_s;
	logic [DW-1:0]          delta;
	logic [SW-1:0]          sum;
	logic [A-1:0]           result;
	logic                   push;

	logic                   out_valid_q;
	logic [A-1:0]           out_amount_q;
	logic                   out_eog_q;
	logic                   skid_valid_q;
	logic [A-1:0]           skid_amount_q;
	logic                   skid_eog_q;
	logic                   take;

	assign en = !skid_valid_q;

	// Stage 1: neighbor sum minus four times the center, exact and signed.
	always_comb begin
		left    = s1_flags.has_left ? left_q : '0;
		nbr_sum = (A+2)'(up) + (A+2)'(s1_cell) + (A+2)'(left) + (A+2)'(right);
		lap     = $signed({1'b0, nbr_sum}) - $signed({1'b0, center, 2'b00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (en && s1_valid) begin
			left_q <= center;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s1_valid) begin
			lap_s2      <= lap;
			center_s2   <= center;
			interior_s2 <= s1_flags.interior;
			eog_s2      <= s1_flags.eog;
		end
	end

	// Stage 2: rate times Laplacian.
	assign rate_s = $signed({1'b0, rate});

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			prod_s3     <= PW'(rate_s) * PW'(lap_s2);
			center_s3   <= center_s2;
			interior_s3 <= interior_s2;
			eog_s3      <= eog_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= s1_valid && s1_flags.emit;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 3: dropping the fraction bits of a signed value floors it.
	always_comb begin
		delta = prod_s3[PW-1:FB];
		sum   = {{(SW-A){1'b0}}, center_s3} + {delta[DW-1], delta};
		if (!interior_s3) begin
			result = center_s3;
		end else if (sum[SW-1]) begin
			result = '0;
		end else if (sum[SW-2:A] != '0) begin
			result = '1;
		end else begin
			result = sum[A-1:0];
		end
	end

	assign push = en && valid_s3;
	assign take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_amount_q <= skid_amount_q;
				out_eog_q    <= skid_eog_q;
			end else if (push) begin
				out_amount_q <= result;
				out_eog_q    <= eog_s3;
			end
		end else if (push) begin
			skid_amount_q <= result;
			skid_eog_q    <= eog_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign new_amount  = out_amount_q;
	assign end_of_grid = out_eog_q;

	// The skid register only ever holds an item behind an occupied output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> (out_valid_q && !skid_valid_q
		&& new_amount == $past(skid_amount_q)))
		else $error("skid item lost when the output drained");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !push)
		else $error("pipeline advanced while the skid register was full");

endmodule
`default_nettype wire

### test/laplacian_diffusion_stencil_top_tb.sv
// Self-checking testbench for the streaming five-point Laplacian diffusion stencil.
module laplacian_diffusion_stencil_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W        = lds_pkg::MAX_WIDTH_DEF;
	localparam longint AMT_MAX  = 65535;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 400;
	localparam int FILL_WIDTH   = 40;
	localparam int TALL_ITEMS   = 40;
	localparam int CYCLE_LIMIT  = 500000;
	localparam logic [lds_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

	localparam int CELLS_RANDOM  = 0;
	localparam int CELLS_EXTREME = 1;
	localparam int CELLS_SMOOTH  = 2;

	localparam int STALL_NONE     = 0;
	localparam int STALL_LIGHT    = 1;
	localparam int STALL_HEAVY    = 2;
	localparam int STALL_PERIODIC = 3;

	typedef struct {
		logic [15:0] amount;
		logic        grid_end;
	} cell_result_t;

	class diffusion_scoreboard;
		logic [lds_pkg::GRID_WIDTH_BITS-1:0]  width_reg;
		logic [lds_pkg::GRID_HEIGHT_BITS-1:0] height_reg;
		logic [lds_pkg::RATE_BITS-1:0]        rate_reg;
		logic [15:0] upper_line [MAX_W];
		logic [15:0] middle_line [MAX_W];
		logic [15:0] prev_center;
		int unsigned col;
		int unsigned row;
		bit row_seen;
		cell_result_t expected_cells[$];
		int failures;

		function new();
			width_reg = lds_pkg::GRID_WIDTH_RESET;
			height_reg = lds_pkg::GRID_HEIGHT_RESET;
			rate_reg = lds_pkg::RATE_RESET;
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			prev_center = '0;
			col = 0;
			row = 0;
			row_seen = 0;
			failures = 0;
		endfunction

		function void set_reg(logic [lds_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [lds_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
				lds_pkg::CFG_GRID_WIDTH:  width_reg = data[lds_pkg::GRID_WIDTH_BITS-1:0];
				lds_pkg::CFG_GRID_HEIGHT: height_reg = data[lds_pkg::GRID_HEIGHT_BITS-1:0];
				lds_pkg::CFG_RATE:        rate_reg = data[lds_pkg::RATE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] diffuse_cell(logic [15:0] up, logic [15:0] down,
				logic [15:0] left, logic [15:0] right, logic [15:0] center);
			longint up_v, down_v, left_v, right_v, center_v, rate_v, lap, prod, total;
			up_v = up;
			down_v = down;
			left_v = left;
			right_v = right;
			center_v = center;
			rate_v = rate_reg;
			lap = up_v + down_v + left_v + right_v - 4 * center_v;
			prod = rate_v * lap;
			// Arithmetic shift of a signed product floors toward minus infinity.
			total = center_v + (prod >>> 16);
			if (total < 0)
				return '0;
			if (total > AMT_MAX)
				return 16'hFFFF;
			return total[15:0];
		endfunction

		function void note_cell(logic [15:0] amount);
			int unsigned w, h;
			logic [15:0] center, right, left, up;
			cell_result_t res;
			w = width_reg;
			h = height_reg;
			if (w == 0) w = 1;
			if (w > MAX_W) w = MAX_W;
			if (h == 0) h = 1;
			if (h > lds_pkg::HEIGHT_LIMIT) h = lds_pkg::HEIGHT_LIMIT;
			if (col >= w) col = w - 1;
			if (row >= h) row = h - 1;
			center = middle_line[col];
			right = (col + 1 < w) ? middle_line[col + 1] : '0;
			left = (col > 0) ? prev_center : '0;
			up = upper_line[col];
			prev_center = center;
			// Each cell leaves one row after it entered; nothing leaves during the first row.
			if (row >= 1 || row_seen) begin
				if (row >= 2 && col >= 1 && col + 1 < w)
					res.amount = diffuse_cell(up, amount, left, right, center);
				else
					res.amount = center;
				res.grid_end = (row == 0 && col == w - 1);
				expected_cells.insert(expected_cells.size(), res);
			end
			upper_line[col] = center;
			middle_line[col] = amount;
			if (col + 1 >= w) begin
				col = 0;
				row_seen = 1;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_result(logic [15:0] amount, logic burst_end, logic grid_end);
			cell_result_t exp_res;
			if (expected_cells.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: amount %0d eob %b eog %b",
						amount, burst_end, grid_end);
				return;
			end
			exp_res = expected_cells[0];
			expected_cells.delete(0);
			if (amount !== exp_res.amount || burst_end !== 1'b1
					|| grid_end !== exp_res.grid_end) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected amount %0d eob 1 eog %b, got amount %0d eob %b eog %b",
						exp_res.amount, exp_res.grid_end, amount, burst_end, grid_end);
			end
		endfunction

		function int pending();
			return expected_cells.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [lds_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [lds_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [lds_pkg::AMOUNT_BITS_DEF-1:0] cell_amount;
	logic out_valid;
	logic out_stall;
	logic [lds_pkg::AMOUNT_BITS_DEF-1:0] new_amount;
	logic end_of_burst;
	logic end_of_grid;

	diffusion_scoreboard sb;
	int burst_left;
	bit hold_request;
	int unsigned cycle_count;

	laplacian_diffusion_stencil_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_amount(cell_amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_amount(new_amount),
		.end_of_burst(end_of_burst),
		.end_of_grid(end_of_grid)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Results are sampled with the values present at the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(new_amount, end_of_burst, end_of_grid);
	end

	// Receiver: stretches of differing stall patterns, plus one long hold on request.
	initial begin
		int mode, span, hold_len;
		bit s;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				hold_len = $urandom_range(200, 400);
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
			end else begin
				mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
				span = $urandom_range(10, 120);
				for (int k = 0; k < span; k++) begin
					case (mode)
						STALL_LIGHT:    s = ($urandom_range(0, 3) == 0);
						STALL_HEAVY:    s = ($urandom_range(0, 3) != 0);
						STALL_PERIODIC: s = (k % 3 == 0);
						default:        s = 1'b0;
					endcase
					out_stall <= s;
					@(posedge clk);
				end
			end
		end
	end

	function automatic logic [15:0] pick_cell(int mode, int base);
		int v;
		case (mode)
			CELLS_EXTREME: begin
				v = $urandom_range(0, 3);
				if (v == 0) return 16'h0000;
				if (v == 1) return 16'hFFFF;
				return 16'($urandom);
			end
			CELLS_SMOOTH: begin
				v = base + $urandom_range(0, 2047) - 1024;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				return 16'(v);
			end
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [lds_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [lds_pkg::CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one item; the sender runs in bursts separated by random gaps.
	task automatic feed_cell(input logic [15:0] amount);
		int gap;
		if (burst_left <= 0) begin
			if ($urandom_range(0, 9) == 0) begin
				burst_left = $urandom_range(100, 300);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cell_amount <= amount;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_cell(amount);
		burst_left--;
	endtask

	// Stops sending and waits until every expected result is out and the pipe is empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int mode, base, phase_len, random_items;
		bit hold_done;
		sb = new();
		cycle_count = 0;
		burst_left = 0;
		hold_request = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= lds_pkg::CFG_GRID_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		cell_amount <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A grid as wide as any later random grid, so both line memories hold data at every column
		// that later grids reach.
		write_reg(lds_pkg::CFG_GRID_WIDTH, {5'($urandom), 11'(FILL_WIDTH)});
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'd3);
		write_reg(lds_pkg::CFG_RATE, 16'h3000);
		for (int i = 0; i < 3 * FILL_WIDTH; i++)
			feed_cell(pick_cell(CELLS_EXTREME, 0));
		settle();

		// Checkerboard at the largest rate drives interior cells into both saturation limits.
		write_reg(lds_pkg::CFG_GRID_WIDTH, 16'd5);
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'd4);
		write_reg(lds_pkg::CFG_RATE, 16'hFFFF);
		for (int i = 0; i < 17; i++)
			feed_cell((i % 2) ? 16'h0000 : 16'hFFFF);
		settle();
		// Shrink the geometry while the position lies past the new bounds.
		write_reg(lds_pkg::CFG_GRID_WIDTH, 16'd2);
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'd2);
		for (int i = 0; i < 3; i++)
			feed_cell(16'($urandom));
		settle();
		// Zero width and height act as one; the unused index must be ignored.
		write_reg(lds_pkg::CFG_GRID_WIDTH, 16'd0);
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'd0);
		write_reg(CFG_UNUSED_INDEX, 16'($urandom));
		for (int i = 0; i < 3; i++)
			feed_cell((i % 2) ? 16'hFFFF : 16'h0000);
		settle();
		// Oversized width and height clamp to their limits.
		write_reg(lds_pkg::CFG_RATE, 16'd0);
		write_reg(lds_pkg::CFG_GRID_WIDTH, 16'hFFFF);
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'hFFFF);
		feed_cell(16'hFFFF);
		feed_cell(16'h8000);
		settle();

		// Tallest grid, one column wide.
		write_reg(lds_pkg::CFG_GRID_WIDTH, 16'd1);
		write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'(lds_pkg::HEIGHT_LIMIT));
		write_reg(lds_pkg::CFG_RATE, 16'h4000);
		for (int i = 0; i < TALL_ITEMS; i++)
			feed_cell(16'($urandom));
		settle();

		random_items = 0;
		hold_done = 0;
		while (random_items < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 60) begin
				case ($urandom_range(0, 19))
					0:          write_reg(lds_pkg::CFG_GRID_WIDTH, {5'($urandom), 11'd0});
					1, 2, 3, 4: write_reg(lds_pkg::CFG_GRID_WIDTH,
						{5'($urandom), 11'($urandom_range(9, FILL_WIDTH))});
					default:    write_reg(lds_pkg::CFG_GRID_WIDTH,
						{5'($urandom), 11'($urandom_range(1, 8))});
				endcase
			end
			if ($urandom_range(0, 99) < 60) begin
				case ($urandom_range(0, 19))
					0:          write_reg(lds_pkg::CFG_GRID_HEIGHT, {3'($urandom), 13'd0});
					1:          write_reg(lds_pkg::CFG_GRID_HEIGHT,
						{3'($urandom), 13'($urandom_range(4096, 8191))});
					2:          write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'($urandom));
					3, 4, 5, 6: write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'($urandom_range(7, 20)));
					default:    write_reg(lds_pkg::CFG_GRID_HEIGHT, 16'($urandom_range(1, 6)));
				endcase
			end
			if ($urandom_range(0, 99) < 60) begin
				case ($urandom_range(0, 9))
					0, 1:    write_reg(lds_pkg::CFG_RATE, 16'd0);
					2, 3:    write_reg(lds_pkg::CFG_RATE, 16'hFFFF);
					4, 5:    write_reg(lds_pkg::CFG_RATE, 16'($urandom_range(16000, 16800)));
					6, 7:    write_reg(lds_pkg::CFG_RATE, 16'($urandom_range(0, 16383)));
					default: write_reg(lds_pkg::CFG_RATE, 16'($urandom));
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_UNUSED_INDEX, 16'($urandom));
			mode = $urandom_range(CELLS_RANDOM, CELLS_SMOOTH);
			base = $urandom_range(0, 65535);
			phase_len = $urandom_range(20, 90);
			if (!hold_done) begin
				// The receiver holds off long enough for the block to stall its input.
				hold_request = 1;
				hold_done = 1;
				phase_len = 150;
			end
			for (int i = 0; i < phase_len; i++)
				feed_cell(pick_cell(mode, base));
			random_items += phase_len;
			settle();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/lds_pkg.sv
hw/rtl/lds_ctrl.sv
hw/rtl/lds_line_buf.sv
hw/rtl/lds_diffuse.sv
hw/rtl/laplacian_diffusion_stencil_top.sv
test/laplacian_diffusion_stencil_top_tb.sv
